/* rtl/rwh_pkg.sv */
// Shared constants and helpers for the rolling window hash unit.
`timescale 1ns / 1ps

package rwh_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int MIN_WINDOW = 3;
  localparam int HASH_W     = 23;
  localparam int BYTE_W     = 8;
  localparam int CFG_W      = 7;
  localparam int POS_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int PROD_W     = HASH_W + BYTE_W;
  localparam int OUT_TDATA_W = ((HASH_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(16);

  typedef logic [HASH_W-1:0] hash_t;

  // Multiplication by the base 257 is an add of the value and its 8-bit shift.
  function automatic hash_t mul257(input hash_t value);
    hash_t result;
    result = value + {value[HASH_W-9:0], 8'd0};
    return result;
  endfunction

endpackage

/* rtl/rolling_window_hash_unit.sv */
// Rolling polynomial hash over a byte stream with a ring of the last window bytes.
`timescale 1ns / 1ps
// The output register captures the hash of each byte transfer that fills a window.
// Throughput: one byte per cycle unless the output is held or a config write waits;
// the oldest ring byte is read one transfer ahead so the registered read never stalls.
// Reset (synchronous, active high) sets the window size to 16 and empties the window.
// A configuration write also empties the window; the output stays ready to drain.

module rolling_window_hash_unit
  import rwh_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [BYTE_W-1:0]      s_tdata,   // data_byte
  input  logic                   s_tuser,   // restart
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // hash_value, then zero padding
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data
);

  logic [BYTE_W-1:0] ring [MAX_WINDOW];
  logic [BYTE_W-1:0] oldest;

  logic [CFG_W-1:0]  window_size;
  hash_t             running_hash;
  logic [CNT_W-1:0]  fill_count;
  logic [POS_W-1:0]  ring_position;
  hash_t             removal_multiplier;
  hash_t             out_hash;
  logic              out_valid;

  logic [CMP_W-1:0]  win;
  logic              accept;
  hash_t             hash_cur;
  logic [CNT_W-1:0]  fill_cur;
  logic [POS_W-1:0]  pos;
  hash_t             mult_cur;
  logic [CMP_W-1:0]  pos_inc;
  logic [POS_W-1:0]  pos_next;
  logic [CMP_W-1:0]  fill_inc;
  logic              filling;
  logic              emit;
  logic [PROD_W-1:0] product;
  hash_t             kept;
  hash_t             hash_next;
  hash_t             mult_next;
  logic [POS_W-1:0]  rd_addr;

  assign cfg_ready = 1'b1;
  assign s_tready  = (!out_valid || m_tready) && !cfg_valid;
  assign accept    = s_tvalid && s_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = OUT_TDATA_W'(out_hash);

  always_comb begin
    if (CMP_W'(window_size) < CMP_W'(MIN_WINDOW)) begin
      win = CMP_W'(MIN_WINDOW);
    end else if (CMP_W'(window_size) > CMP_W'(MAX_WINDOW)) begin
      win = CMP_W'(MAX_WINDOW);
    end else begin
      win = CMP_W'(window_size);
    end
  end

  always_comb begin
    if (s_tuser) begin
      hash_cur = '0;
      fill_cur = '0;
      pos      = '0;
      mult_cur = HASH_W'(1);
    end else begin
      hash_cur = running_hash;
      fill_cur = fill_count;
      pos      = (CMP_W'(ring_position) >= win) ? '0 : ring_position;
      mult_cur = removal_multiplier;
    end
    pos_inc  = CMP_W'(pos) + CMP_W'(1);
    pos_next = (pos_inc >= win) ? '0 : pos_inc[POS_W-1:0];
    fill_inc = CMP_W'(fill_cur) + CMP_W'(1);
    filling  = CMP_W'(fill_cur) < win;
    product  = PROD_W'(oldest) * PROD_W'(mult_cur);
    kept     = hash_cur - product[HASH_W-1:0];
    if (filling) begin
      hash_next = mul257(hash_cur) + HASH_W'(s_tdata);
      emit      = !(fill_inc < win);
      mult_next = emit ? mult_cur : mul257(mult_cur);
    end else begin
      hash_next = mul257(kept) + HASH_W'(s_tdata);
      emit      = 1'b1;
      mult_next = mult_cur;
    end
    rd_addr = accept ? pos_next : ring_position;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[pos] <= s_tdata;
    end
    oldest <= ring[rd_addr];
    if (accept && emit) begin
      out_hash <= hash_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size        <= WINDOW_RESET;
      running_hash       <= '0;
      fill_count         <= '0;
      ring_position      <= '0;
      removal_multiplier <= HASH_W'(1);
      out_valid          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        window_size        <= cfg_data;
        running_hash       <= '0;
        fill_count         <= '0;
        ring_position      <= '0;
        removal_multiplier <= HASH_W'(1);
      end else if (accept) begin
        running_hash       <= hash_next;
        ring_position      <= pos_next;
        removal_multiplier <= mult_next;
        if (filling) begin
          fill_count <= fill_inc[CNT_W-1:0];
        end else begin
          fill_count <= fill_cur;
        end
      end
      if (accept && emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* verif/rolling_window_hash_checker.sv */
// Checker for the rolling window hash unit: it tracks the window state and compares each hash.
`timescale 1ns / 1ps

module rolling_window_hash_checker
  import rwh_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [BYTE_W-1:0]      s_tdata,
  input  logic                   s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data,
  output int                     pending,
  output int                     failures
);

  localparam hash_t HASH_BASE = hash_t'(257);

  logic [CFG_W-1:0]  window_cfg;
  logic [BYTE_W-1:0] ring [MAX_WINDOW];
  hash_t             run_hash;
  hash_t             drop_mult;
  logic [CFG_W-1:0]  fill_cnt;
  logic [POS_W-1:0]  ring_pos;
  hash_t             hash_q [$];
  int                errs = 0;

  function automatic logic [CFG_W-1:0] clamp_window(input logic [CFG_W-1:0] size);
    logic [CFG_W-1:0] w;
    w = size;
    if (w < CFG_W'(MIN_WINDOW)) w = CFG_W'(MIN_WINDOW);
    if (w > CFG_W'(MAX_WINDOW)) w = CFG_W'(MAX_WINDOW);
    return w;
  endfunction

  task automatic empty_window();
    run_hash  = '0;
    fill_cnt  = '0;
    ring_pos  = '0;
    drop_mult = hash_t'(1);
  endtask

  task automatic roll_byte(input logic [BYTE_W-1:0] b, input logic fresh);
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] pos;
    logic [CFG_W-1:0] nxt;
    hash_t            removed;
    logic             emit;
    w = clamp_window(window_cfg);
    if (fresh) empty_window();
    pos = CFG_W'(ring_pos);
    if (pos >= w) pos = '0;
    nxt = (pos + CFG_W'(1) >= w) ? '0 : pos + CFG_W'(1);
    emit = 1'b1;
    if (fill_cnt < w) begin
      run_hash = run_hash * HASH_BASE + hash_t'(b);
      fill_cnt = fill_cnt + CFG_W'(1);
      if (fill_cnt < w) begin
        drop_mult = drop_mult * HASH_BASE;
        emit = 1'b0;
      end
    end else begin
      removed  = hash_t'(ring[pos[POS_W-1:0]]) * drop_mult;
      run_hash = (run_hash - removed) * HASH_BASE + hash_t'(b);
    end
    ring[pos[POS_W-1:0]] = b;
    ring_pos = nxt[POS_W-1:0];
    if (emit) hash_q.push_back(run_hash);
  endtask

  always @(posedge clk) begin
    hash_t want;
    if (rst) begin
      window_cfg = WINDOW_RESET;
      empty_window();
      hash_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (hash_q.size() == 0) begin
          $error("hash_value: expected no transfer, actual %0h", m_tdata[HASH_W-1:0]);
          errs++;
        end else begin
          want = hash_q.pop_front();
          if (m_tdata[HASH_W-1:0] !== want) begin
            $error("hash_value: expected %0h, actual %0h", want, m_tdata[HASH_W-1:0]);
            errs++;
          end
        end
        if (m_tdata[OUT_TDATA_W-1:HASH_W] !== '0) begin
          $error("padding: expected 0, actual %0h", m_tdata[OUT_TDATA_W-1:HASH_W]);
          errs++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        window_cfg = cfg_data;
        empty_window();
      end
      if (s_tvalid && s_tready) roll_byte(s_tdata, s_tuser);
    end
    pending  <= hash_q.size();
    failures <= errs;
  end

endmodule

/* verif/rolling_window_hash_unit_test.sv */
// Stimulus and verdict for the rolling window hash unit, with the checker beside the block.
`timescale 1ns / 1ps

module rolling_window_hash_unit_test;
  import rwh_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 105;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [BYTE_W-1:0]      s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data = '0;

  logic s_fire = 1'b0;
  logic cfg_fire = 1'b0;
  int   pending;
  int   failures;
  int   idle_cycles = 0;
  bit   squeeze_req = 1'b0;
  bit   squeeze_done = 1'b0;

  always #1 clk = ~clk;

  rolling_window_hash_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  rolling_window_hash_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .failures  (failures)
  );

  always @(posedge clk) begin
    s_fire   <= s_tvalid && s_tready && !rst;
    cfg_fire <= cfg_valid && cfg_ready && !rst;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // The receiver stalls in segments of varying density, and holds off once for a long stretch.
  initial begin
    int seg_len;
    int mode;
    int k;
    @(negedge clk);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        squeeze_done = 1'b1;
      end else begin
        seg_len = $urandom_range(10, 120);
        mode    = $urandom_range(0, 3);
        for (k = 0; k < seg_len && !(squeeze_req && !squeeze_done); k++) begin
          case (mode)
            0: begin
              m_tready <= 1'b1;
            end
            1: begin
              m_tready <= ($urandom_range(0, 99) < 70);
            end
            2: begin
              m_tready <= ($urandom_range(0, 99) < 30);
            end
            default: begin
              m_tready <= (k % 3 != 0);
            end
          endcase
          @(negedge clk);
        end
      end
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fresh);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= fresh;
    do @(negedge clk); while (!s_fire);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] size);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_stream(input int count, input int restart_pct, input bit steady);
    int burst;
    int gap;
    int i;
    burst = $urandom_range(1, 40);
    for (i = 0; i < count; i++) begin
      push_byte(pick_byte(), $urandom_range(0, 99) < restart_pct);
      if (!steady) begin
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 40);
          gap   = $urandom_range(0, 10);
          if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
          end
        end
      end
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] lead [8];
    bit                lead_rs [8];
    int                sizes [13];
    int                i;
    lead    = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80};
    lead_rs = '{0, 0, 0, 1, 1, 0, 0, 0};
    sizes   = '{0, 127, 3, 64, 1, 2, 65, 5, 100, 16, 31, 4, 63};
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Window size from reset: alternating extremes, results on the last two bytes.
    for (i = 0; i < 17; i++) begin
      if (i == 8) begin
        push_byte(8'h80, 1'b0);
      end else if (i == 16) begin
        push_byte(8'h7F, 1'b0);
      end else begin
        push_byte((i % 2 == 0) ? 8'hFF : 8'h00, i == 0);
      end
    end
    drain();

    // Smallest window: restart after a full window and again while filling.
    write_window(CFG_W'(MIN_WINDOW));
    for (i = 0; i < 8; i++) push_byte(lead[i], lead_rs[i]);
    drain();

    for (i = 0; i < 16; i++) begin
      write_window((i < 13) ? CFG_W'(sizes[i]) : CFG_W'($urandom_range(0, 127)));
      if (i == 2) begin
        squeeze_req = 1'b1;
        send_stream(PHASE_ITEMS, 2, 1'b1);
      end else begin
        send_stream(PHASE_ITEMS, (i % 4 == 3) ? 12 : 2, i % 4 == 1);
      end
      drain();
    end

    repeat (8) @(negedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
